>>> rtl/hcp_pkg.sv
// Shared types, constants and character helpers for the hex colour command parser.
`timescale 1ns / 1ps
`default_nettype none
package hcp_pkg;

  localparam logic [7:0] KeyEsc      = 8'd27;
  localparam logic [7:0] KeyDel      = 8'd127;
  localparam logic [7:0] KeyCr       = 8'd13;
  localparam logic [7:0] CharHash    = 8'h23;
  localparam logic [7:0] CharBracket = 8'h5B;
  localparam logic [7:0] CharArrowLo = 8'h41;
  localparam logic [7:0] CharArrowHi = 8'h44;

  localparam int unsigned LineDepth = 7;
  localparam logic [2:0]  LineLen   = 3'd7;

  localparam logic [7:0] RedReset   = 8'd255;
  localparam logic [7:0] GreenReset = 8'd94;
  localparam logic [7:0] BlueReset  = 8'd0;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_LEN = 2'd1,
    ST_FMT = 2'd2
  } status_t;

  typedef struct packed {
    logic [LineDepth-1:0][7:0] chars;
    logic [2:0]                fill;
  } line_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] bad_char;
    logic       ok;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } check_t;

  function automatic logic hex_ok(input logic [7:0] ch);
    hex_ok = (ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h41 && ch <= 8'h46) ||
             (ch >= 8'h61 && ch <= 8'h66);
  endfunction

  // letters have bit 6 set and low nibble 1..6 for A..F / a..f
  function automatic logic [3:0] hex_val(input logic [7:0] ch);
    hex_val = ch[6] ? (ch[3:0] + 4'd9) : ch[3:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/hcp_line_edit.sv
// Line store with delete, escape swallowing and fill count.
`timescale 1ns / 1ps
`default_nettype none
module hcp_line_edit (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,
  input  wire logic [7:0]    rx_byte,
  output hcp_pkg::line_t     line
);

  typedef enum logic [2:0] {
    ESC_IDLE    = 3'b001,
    ESC_SEEN    = 3'b010,
    ESC_BRACKET = 3'b100
  } esc_state_t;

  logic [hcp_pkg::LineDepth-1:0][7:0] chars_r;
  logic [2:0]                         fill_r, fill_nxt;
  esc_state_t                         esc_r, esc_nxt;
  logic                               keep;
  logic                               store;

  // escape filter: decides whether a plain byte is kept
  always_comb begin
    keep    = 1'b1;
    esc_nxt = ESC_IDLE;
    if (rx_byte == hcp_pkg::KeyEsc) begin
      keep    = 1'b0;
      esc_nxt = ESC_SEEN;
    end else begin
      unique case (esc_r)
        ESC_SEEN: begin
          if (rx_byte == hcp_pkg::CharBracket) begin
            keep    = 1'b0;
            esc_nxt = ESC_BRACKET;
          end
        end
        ESC_BRACKET: begin
          keep = !(rx_byte >= hcp_pkg::CharArrowLo && rx_byte <= hcp_pkg::CharArrowHi);
        end
        default: keep = 1'b1;
      endcase
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    store    = 1'b0;
    priority if (rx_byte == hcp_pkg::KeyDel) begin
      if (fill_r != 3'd0) fill_nxt = fill_r - 3'd1;
    end else if (rx_byte == hcp_pkg::KeyCr) begin
      fill_nxt = 3'd0;
    end else begin
      // a full line drops plain bytes
      if (fill_r < hcp_pkg::LineLen) begin
        store = keep;
        if (keep) fill_nxt = fill_r + 3'd1;
      end
    end
  end

  // escape phase moves only for plain bytes while the line has room
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 3'd0;
      esc_r  <= ESC_IDLE;
    end else if (step) begin
      fill_r <= fill_nxt;
      if (rx_byte != hcp_pkg::KeyDel && rx_byte != hcp_pkg::KeyCr &&
          fill_r < hcp_pkg::LineLen) begin
        esc_r <= esc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && store) chars_r[fill_r] <= rx_byte;
  end

  assign line.chars = chars_r;
  assign line.fill  = fill_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= hcp_pkg::LineLen)
    else $error("line fill count above line length");

  a_cr_empties: assert property (@(posedge clk) disable iff (!rst_n)
    step && rx_byte == hcp_pkg::KeyCr |=> fill_r == 3'd0)
    else $error("carriage return did not empty the line");

  a_del_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    step && rx_byte == hcp_pkg::KeyDel && fill_r != 3'd0 |=>
      fill_r == $past(fill_r) - 3'd1)
    else $error("delete did not drop one character");
`endif

endmodule
`default_nettype wire

>>> rtl/hcp_line_check.sv
// Line validation and hex pair decode at carriage return.
`timescale 1ns / 1ps
`default_nettype none
module hcp_line_check (
  input  wire hcp_pkg::line_t line,
  input  wire logic [7:0]     red_level,
  input  wire logic [7:0]     green_level,
  input  wire logic [7:0]     blue_level,
  output hcp_pkg::check_t     result
);

  logic       found;
  logic [7:0] bad;

  // first non-hex digit among positions one to six
  always_comb begin
    found = 1'b0;
    bad   = 8'd0;
    for (int i = 1; i < hcp_pkg::LineDepth; i++) begin
      if (!found && !hcp_pkg::hex_ok(line.chars[i])) begin
        found = 1'b1;
        bad   = line.chars[i];
      end
    end
  end

  always_comb begin
    result.status   = hcp_pkg::ST_OK;
    result.bad_char = 8'd0;
    result.ok       = 1'b0;
    priority if (line.fill != hcp_pkg::LineLen) begin
      result.status = hcp_pkg::ST_LEN;
    end else if (line.chars[0] != hcp_pkg::CharHash) begin
      result.status   = hcp_pkg::ST_FMT;
      result.bad_char = line.chars[0];
    end else if (found) begin
      result.status   = hcp_pkg::ST_FMT;
      result.bad_char = bad;
    end else begin
      result.ok = 1'b1;
    end
    if (result.ok) begin
      result.red   = {hcp_pkg::hex_val(line.chars[1]), hcp_pkg::hex_val(line.chars[2])};
      result.green = {hcp_pkg::hex_val(line.chars[3]), hcp_pkg::hex_val(line.chars[4])};
      result.blue  = {hcp_pkg::hex_val(line.chars[5]), hcp_pkg::hex_val(line.chars[6])};
    end else begin
      result.red   = red_level;
      result.green = green_level;
      result.blue  = blue_level;
    end
  end

endmodule
`default_nettype wire

>>> rtl/hex_color_command_parser.sv
// Top level: input register, line edit, line check, duty levels and result register.
`timescale 1ns / 1ps
`default_nettype none
// Takes one terminal byte per cycle and edits a seven-character command line
// ("#RRGGBB", hex in either case). Delete (127) removes the last character,
// ESC / ESC '[' / ESC '[' A-D are swallowed, and carriage return checks the
// line and yields one result: status, offending character and the current
// red, green and blue duties. No other byte yields a result. Bytes are
// registered on entry and processed from that input register, and a carriage
// return's result is then registered in the output register. Throughput is
// one byte per cycle; the input stalls only when a carriage return meets a
// result register that is still waiting to be taken.
// Duties reset to 255/94/0.
module hex_color_command_parser (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_status,
  output logic [7:0]      out_bad_char,
  output logic [7:0]      out_red_duty,
  output logic [7:0]      out_green_duty,
  output logic [7:0]      out_blue_duty
);

  logic            s1_valid_r;
  logic [7:0]      s1_byte_r;
  logic            s1_is_cr;
  logic            s1_adv;
  logic            out_free;
  logic            res_load;
  hcp_pkg::line_t  line;
  hcp_pkg::check_t chk;

  logic [7:0]      red_r, green_r, blue_r;
  logic            out_valid_r;
  logic [1:0]      status_r;
  logic [7:0]      bad_r, red_out_r, green_out_r, blue_out_r;

  assign s1_is_cr = s1_byte_r == hcp_pkg::KeyCr;
  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && (!s1_is_cr || out_free);
  assign res_load = s1_adv && s1_is_cr;
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) s1_byte_r <= in_rx_byte;
  end

  hcp_line_edit u_edit (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_adv),
    .rx_byte (s1_byte_r),
    .line    (line)
  );

  hcp_line_check u_check (
    .line        (line),
    .red_level   (red_r),
    .green_level (green_r),
    .blue_level  (blue_r),
    .result      (chk)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_r   <= hcp_pkg::RedReset;
      green_r <= hcp_pkg::GreenReset;
      blue_r  <= hcp_pkg::BlueReset;
    end else if (res_load && chk.ok) begin
      red_r   <= chk.red;
      green_r <= chk.green;
      blue_r  <= chk.blue;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      status_r    <= chk.status;
      bad_r       <= chk.bad_char;
      red_out_r   <= chk.red;
      green_out_r <= chk.green;
      blue_out_r  <= chk.blue;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_bad_char   = bad_r;
  assign out_red_duty   = red_out_r;
  assign out_green_duty = green_out_r;
  assign out_blue_duty  = blue_out_r;

`ifndef SYNTHESIS
  a_cr_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> out_valid_r)
    else $error("carriage return transfer produced no result");

  a_ok_latches: assert property (@(posedge clk) disable iff (!rst_n)
    res_load && chk.ok |=> red_r == red_out_r && green_r == green_out_r &&
      blue_r == blue_out_r)
    else $error("accepted colour not reflected in duty registers");

  a_stall_only_on_cr: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |-> s1_is_cr && out_valid_r && !out_ready)
    else $error("input stage stalled without a pending result");
`endif

endmodule
`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for the hex colour command parser: stimulus, prediction and checks.
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned RandomBytes = 1050;
  localparam int unsigned IdlePct     = 16;
  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned HoldCycles  = 120;
  localparam int unsigned PrintCap    = 40;

  localparam logic [1:0] EscIdle    = 2'd0;
  localparam logic [1:0] EscSeen    = 2'd1;
  localparam logic [1:0] EscBracket = 2'd2;

  typedef struct {
    hcp_pkg::status_t status;
    logic [7:0]       bad_char;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
  } colour_result_t;

  typedef struct {
    logic [7:0]     ch;
    bit             typed;
    colour_result_t res;
  } stim_row_t;

  localparam colour_result_t NoRes = '{hcp_pkg::ST_OK, 8'h00, 8'h00, 8'h00, 8'h00};

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_status;
  logic [7:0] out_bad_char;
  logic [7:0] out_red_duty;
  logic [7:0] out_green_duty;
  logic [7:0] out_blue_duty;

  // predictor state
  logic [7:0] line_buf [hcp_pkg::LineDepth];
  int         line_fill = 0;
  logic [1:0] esc_phase = EscIdle;
  logic [7:0] duty_r = hcp_pkg::RedReset;
  logic [7:0] duty_g = hcp_pkg::GreenReset;
  logic [7:0] duty_b = hcp_pkg::BlueReset;

  stim_row_t      stim_q [$];
  stim_row_t      directed_rows [31];
  colour_result_t expected_colours [$];
  colour_result_t predicted_res;
  colour_result_t want;

  int unsigned next_idx = 0;
  int unsigned sent_cnt = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;
  int unsigned hold_left = 0;
  bit          held_once = 1'b0;
  int unsigned n_ok = 0, n_len = 0, n_fmt = 0;

  hex_color_command_parser u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_bad_char  (out_bad_char),
    .out_red_duty  (out_red_duty),
    .out_green_duty(out_green_duty),
    .out_blue_duty (out_blue_duty)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bit 4 set means not a hex digit
  function automatic logic [4:0] hex_code(input logic [7:0] ch);
    if (ch >= "0" && ch <= "9") return {1'b0, 4'(ch - "0")};
    if (ch >= "A" && ch <= "F") return {1'b0, 4'(ch - "A" + 8'd10)};
    if (ch >= "a" && ch <= "f") return {1'b0, 4'(ch - "a" + 8'd10)};
    return 5'h10;
  endfunction

  function automatic logic [7:0] pair_val(input logic [7:0] hi_ch, input logic [7:0] lo_ch);
    logic [4:0] hi_code;
    logic [4:0] lo_code;
    hi_code = hex_code(hi_ch);
    lo_code = hex_code(lo_ch);
    return {hi_code[3:0], lo_code[3:0]};
  endfunction

  // line editor and checker; returns 1 when the byte yields a result
  function automatic bit parse_byte(input logic [7:0] ch, output colour_result_t res);
    bit keep;
    logic [4:0] code;
    res = '{hcp_pkg::ST_OK, 8'h00, duty_r, duty_g, duty_b};
    if (ch == hcp_pkg::KeyDel) begin
      if (line_fill > 0) line_fill--;
      return 1'b0;
    end
    if (ch != hcp_pkg::KeyCr) begin
      // escape phase only moves while the line has room
      if (line_fill < hcp_pkg::LineDepth) begin
        keep = 1'b1;
        if (ch == hcp_pkg::KeyEsc) begin
          esc_phase = EscSeen;
          keep = 1'b0;
        end else if (esc_phase == EscSeen) begin
          esc_phase = EscIdle;
          if (ch == hcp_pkg::CharBracket) begin
            esc_phase = EscBracket;
            keep = 1'b0;
          end
        end else if (esc_phase == EscBracket) begin
          esc_phase = EscIdle;
          keep = !(ch >= hcp_pkg::CharArrowLo && ch <= hcp_pkg::CharArrowHi);
        end else begin
          esc_phase = EscIdle;
        end
        if (keep) begin
          line_buf[line_fill] = ch;
          line_fill++;
        end
      end
      return 1'b0;
    end
    if (line_fill != hcp_pkg::LineDepth) begin
      res.status = hcp_pkg::ST_LEN;
    end else if (line_buf[0] != hcp_pkg::CharHash) begin
      res.status   = hcp_pkg::ST_FMT;
      res.bad_char = line_buf[0];
    end else begin
      for (int k = 1; k < hcp_pkg::LineDepth; k++) begin
        code = hex_code(line_buf[k]);
        if (res.status == hcp_pkg::ST_OK && code[4]) begin
          res.status   = hcp_pkg::ST_FMT;
          res.bad_char = line_buf[k];
        end
      end
      if (res.status == hcp_pkg::ST_OK) begin
        duty_r = pair_val(line_buf[1], line_buf[2]);
        duty_g = pair_val(line_buf[3], line_buf[4]);
        duty_b = pair_val(line_buf[5], line_buf[6]);
      end
    end
    line_fill = 0;
    res.red   = duty_r;
    res.green = duty_g;
    res.blue  = duty_b;
    return 1'b1;
  endfunction

  function automatic logic [7:0] rand_hex_char();
    int unsigned d;
    d = $urandom_range(0, 15);
    if (d < 10) return 8'("0" + d);
    return 8'(($urandom_range(0, 1) ? "a" : "A") + d - 10);
  endfunction

  task automatic queue_byte(input logic [7:0] ch);
    stim_q.push_back('{ch, 1'b0, NoRes});
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] exp_val);
    if (mismatches < PrintCap)
      $display("MISMATCH result %0d: %s got %02h expected %02h",
               results_seen, what, got, exp_val);
    mismatches++;
  endtask

  // sender: offers bytes, predicts on each transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (parse_byte(in_rx_byte, predicted_res)) begin
          if (stim_q[sent_cnt].typed) expected_colours.push_back(stim_q[sent_cnt].res);
          else expected_colours.push_back(predicted_res);
        end
        sent_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (next_idx < stim_q.size() &&
            ((next_idx >= 600 && next_idx < 800) || $urandom_range(0, 99) >= IdlePct)) begin
          in_valid   <= 1'b1;
          in_rx_byte <= stim_q[next_idx].ch;
          next_idx++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result transfer, with one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_colours.size() == 0) begin
          report_mismatch("unexpected result, status", {6'd0, out_status}, 8'h00);
        end else begin
          want = expected_colours.pop_front();
          if (out_status != want.status)
            report_mismatch("status", {6'd0, out_status}, {6'd0, want.status});
          if (out_bad_char != want.bad_char)
            report_mismatch("bad_char", out_bad_char, want.bad_char);
          if (out_red_duty != want.red) report_mismatch("red", out_red_duty, want.red);
          if (out_green_duty != want.green)
            report_mismatch("green", out_green_duty, want.green);
          if (out_blue_duty != want.blue) report_mismatch("blue", out_blue_duty, want.blue);
          case (want.status)
            hcp_pkg::ST_OK:  n_ok++;
            hcp_pkg::ST_LEN: n_len++;
            default:         n_fmt++;
          endcase
        end
        results_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!held_once && results_seen == 30) begin
        held_once = 1'b1;
        hold_left = HoldCycles;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (results_seen >= 70 && results_seen < 95) ||
                     $urandom_range(0, 99) >= IdlePct;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned kind;
    int unsigned n_chars;
    logic [7:0]  c;

    directed_rows = '{
      '{hcp_pkg::KeyCr, 1'b1, '{hcp_pkg::ST_LEN, 8'h00, hcp_pkg::RedReset,
                               hcp_pkg::GreenReset, hcp_pkg::BlueReset}},
      '{"#", 1'b0, NoRes}, '{"0", 1'b0, NoRes}, '{"0", 1'b0, NoRes},
      '{"f", 1'b0, NoRes}, '{"F", 1'b0, NoRes}, '{"A", 1'b0, NoRes}, '{"a", 1'b0, NoRes},
      '{hcp_pkg::KeyCr, 1'b1, '{hcp_pkg::ST_OK, 8'h00, 8'h00, 8'hFF, 8'hAA}},
      // delete on an empty line, then a full line drops the eighth character
      '{hcp_pkg::KeyDel, 1'b0, NoRes},
      '{"Z", 1'b0, NoRes}, '{"1", 1'b0, NoRes}, '{"2", 1'b0, NoRes}, '{"3", 1'b0, NoRes},
      '{"4", 1'b0, NoRes}, '{"5", 1'b0, NoRes}, '{"6", 1'b0, NoRes}, '{"7", 1'b0, NoRes},
      '{hcp_pkg::KeyCr, 1'b1, '{hcp_pkg::ST_FMT, "Z", 8'h00, 8'hFF, 8'hAA}},
      // arrow swallowed, lone ESC then '#' stored, zero byte as a bad character
      '{hcp_pkg::KeyEsc, 1'b0, NoRes}, '{hcp_pkg::CharBracket, 1'b0, NoRes},
      '{hcp_pkg::CharArrowHi, 1'b0, NoRes},
      '{hcp_pkg::KeyEsc, 1'b0, NoRes}, '{"#", 1'b0, NoRes},
      '{"a", 1'b0, NoRes}, '{"b", 1'b0, NoRes}, '{"c", 1'b0, NoRes}, '{"d", 1'b0, NoRes},
      '{"e", 1'b0, NoRes}, '{8'h00, 1'b0, NoRes},
      '{hcp_pkg::KeyCr, 1'b1, '{hcp_pkg::ST_FMT, 8'h00, 8'h00, 8'hFF, 8'hAA}}
    };
    foreach (directed_rows[i]) stim_q.push_back(directed_rows[i]);

    // mostly well-formed lines with random content, some short/long, some noise
    while (stim_q.size() < RandomBytes + $size(directed_rows)) begin
      kind = $urandom_range(0, 99);
      if (kind < 85) begin
        n_chars = (kind < 70) ? 7 : $urandom_range(0, 9);
        queue_byte(($urandom_range(0, 99) < 5) ? 8'($urandom_range(0, 255))
                                               : hcp_pkg::CharHash);
        for (int k = 1; k < n_chars; k++) begin
          c = rand_hex_char();
          if ($urandom_range(0, 99) < 6) c = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 99) < 5) begin
            queue_byte(rand_hex_char());
            queue_byte(hcp_pkg::KeyDel);
          end
          if ($urandom_range(0, 99) < 5) begin
            queue_byte(hcp_pkg::KeyEsc);
            queue_byte(hcp_pkg::CharBracket);
            // range spans one code either side of the arrow codes
            queue_byte(8'($urandom_range(hcp_pkg::CharArrowLo - 1,
                                         hcp_pkg::CharArrowHi + 1)));
          end
          queue_byte(c);
        end
        queue_byte(hcp_pkg::KeyCr);
      end else begin
        n_chars = $urandom_range(1, 12);
        for (int k = 0; k < n_chars; k++) queue_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1)) queue_byte(hcp_pkg::KeyCr);
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (sent_cnt < stim_q.size() || expected_colours.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d bytes incl. edits, escapes and noise; checked %0d lines", sent_cnt,
             results_seen);
    $display("Lines: %0d colour, %0d length error, %0d format error; %0d mismatches",
             n_ok, n_len, n_fmt, mismatches);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/hcp_pkg.sv
rtl/hcp_line_edit.sv
rtl/hcp_line_check.sv
rtl/hex_color_command_parser.sv
sim/testbench.sv
